// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the sketch rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define HHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define HHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hhs_pkg.sv =====
// ----------------------------------------------------------------------------
// hhs_pkg
// Types, constants and codes shared by the heavy hitter sketch rtl.
// ----------------------------------------------------------------------------
package hhs_pkg;

	// default geometry
	localparam int HHS_ROWS    = 4;
	localparam int HHS_BUCKETS = 256;
	localparam int HHS_STREAMS = 4;

	// hash mix constants
	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] MIX_C3  = 32'h85ebca6b;
	localparam logic [31:0] MIX_C4  = 32'hc2b2ae35;
	localparam logic [31:0] MIX_M5  = 32'd5;

	// configuration registers
	localparam int          SEED_REGS   = 4;
	localparam logic [2:0]  REG_BKT     = 3'd4;
	localparam int          MAX_BKT_CFG = 256;
	localparam logic [8:0]  BKT_RESET   = 9'd256;

	// modulo unit shape
	localparam int DVD_W    = 32;
	localparam int MOD_STEP = 4;
	localparam int REM_W    = 8;

	// row counter covers up to eight rows
	localparam int ROW_CNT_W = 3;

	localparam logic [31:0] CNT_MAX = 32'hffffffff;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_MERGE  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_H5,
		ST_C3,
		ST_C4,
		ST_HF,
		ST_MOD,
		ST_ONE_RD,
		ST_WR,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/hhs_ram.sv =====
// ----------------------------------------------------------------------------
// hhs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/hhs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hhs_mod_unit
// Iterative remainder of a 32-bit hash by a bucket count of at most 256,
// restoring method, four dividend bits a cycle.
// ----------------------------------------------------------------------------
module hhs_mod_unit import hhs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [REM_W:0]   divisor,
	output logic             done,
	output logic [REM_W-1:0] remainder
);

	localparam int STEPS = DVD_W / MOD_STEP;
	localparam int CNT_W = $clog2(STEPS);

	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] rem_d;
	logic [REM_W:0]   t;

	// one group of restoring steps
	always_comb begin
		t = {1'b0, rem_q};
		for (int i = 0; i < MOD_STEP; i++) begin
			t = {t[REM_W-1:0], dvd_q[DVD_W-1-i]};
			if (t >= divisor) begin
				t = t - divisor;
			end
		end
		rem_d = t[REM_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_STEP;
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/heavy_hitter_sketch_unit.sv =====
// ----------------------------------------------------------------------------
// heavy_hitter_sketch_unit
// Per-stream majority-vote sketch of ROWS x BUCKETS entries, with insert,
// merge and read requests and an APB-style configuration port.
// ----------------------------------------------------------------------------
// After reset the store is swept to zero, one entry a cycle, over all
// STREAMS*ROWS*BUCKETS entries (4096 by default); no request is taken then.
// A request is taken only while the sequencer is idle. Read and merge pass
// through a store read, a write state that writes back only for merge, and
// the done state. Insert hashes the key on the shared 32x32 multiplier; per
// row the multiplier runs three hash steps, the modulo unit reduces the
// hash, and the bucket is read and written back. Skipped, ignored or
// out-of-range requests go straight to the done state. A finished result
// sits in an output register; a new request can be taken while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heavy_hitter_sketch_unit import hhs_pkg::*; #(
	parameter int ROWS    = HHS_ROWS,
	parameter int BUCKETS = HHS_BUCKETS,
	parameter int STREAMS = HHS_STREAMS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic [1:0]  stream,
	input  logic [31:0] value,
	input  logic [1:0]  row,
	input  logic [7:0]  bucket,
	input  logic [31:0] remote_count,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] entry_key,
	output logic [31:0] entry_count,
	output logic        skipped
);

	localparam int DEPTH   = STREAMS * ROWS * BUCKETS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int BKT_CAP = (BUCKETS < MAX_BKT_CFG) ? BUCKETS : MAX_BKT_CFG;

	state_t state_q, state_d;

	// configuration
	logic [31:0] seed_q [SEED_REGS];
	logic [8:0]  bkt_cfg_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	// request fields
	op_t         op_q;
	logic [1:0]  stream_q;
	logic [31:0] value_q;
	logic [1:0]  rowf_q;
	logic [7:0]  bucketf_q;
	logic [31:0] rc_q;

	// working registers
	logic [ROW_CNT_W-1:0] row_q;
	logic [31:0]          k_q;
	logic [31:0]          mul_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    clr_q;
	logic [31:0]          res_key_q;
	logic [31:0]          res_cnt_q;
	logic                 res_skip_q;

	// output register
	logic        result_valid_q;
	logic [31:0] entry_key_q;
	logic [31:0] entry_count_q;
	logic        skipped_q;

	// combinational
	logic              accept;
	logic              bad_req;
	logic              skip_req;
	logic              last_row;
	logic              out_free;
	logic [31:0]       mul_a, mul_b, prod, mix_m, seed_sel, hash_fin;
	logic [8:0]        nb;
	logic              mod_start, mod_done;
	logic [REM_W-1:0]  mod_rem;
	logic [ADDR_W-1:0] ins_addr, one_addr, raddr, waddr;
	logic              ram_we;
	logic [63:0]       rdata, wdata;
	logic [31:0]       rd_key, rd_cnt;
	logic [31:0]       upd_key, upd_cnt, c1;
	logic [32:0]       msum;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		if (32'(reg_idx) < SEED_REGS) begin
			prdata = seed_q[reg_idx[1:0]];
		end else if (reg_idx == REG_BKT) begin
			prdata = {23'd0, bkt_cfg_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEED_REGS; i++) begin
				seed_q[i] <= 32'(2 * i + 1);
			end
			bkt_cfg_q <= BKT_RESET;
		end else if (cfg_wr) begin
			if (32'(reg_idx) < SEED_REGS) begin
				seed_q[reg_idx[1:0]] <= pwdata;
			end else if (reg_idx == REG_BKT) begin
				bkt_cfg_q <= pwdata[8:0];
			end
		end
	end

	// request classification
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign bad_req    = (32'(stream) >= STREAMS) || (op == OP_NONE)
		|| ((op != OP_INSERT) && ((32'(row) >= ROWS) || (32'(bucket) >= BUCKETS)));
	assign skip_req   = (op == OP_INSERT) && (value == 32'd0);
	assign last_row   = (row_q == ROW_CNT_W'(ROWS - 1));
	assign out_free   = !result_valid_q || !result_stall;

	// effective bucket count
	always_comb begin
		if (bkt_cfg_q == 9'd0) begin
			nb = 9'd1;
		end else if (32'(bkt_cfg_q) > BKT_CAP) begin
			nb = 9'(BKT_CAP);
		end else begin
			nb = bkt_cfg_q;
		end
	end

	// row seed
	assign seed_sel = (32'(row_q) < SEED_REGS) ? seed_q[row_q[1:0]] : 32'(2 * row_q + 1);

	// shared multiplier operand selection
	assign mix_m = mul_q + MIX_ADD;
	always_comb begin
		unique case (state_q)
			ST_K1: begin
				mul_a = value_q;
				mul_b = MIX_C1;
			end
			ST_K2: begin
				mul_a = {mul_q[16:0], mul_q[31:17]};
				mul_b = MIX_C2;
			end
			ST_H5: begin
				mul_a = {seed_sel[18:0] ^ k_q[18:0], seed_sel[31:19] ^ k_q[31:19]};
				mul_b = MIX_M5;
			end
			ST_C3: begin
				mul_a = mix_m ^ (mix_m >> 16);
				mul_b = MIX_C3;
			end
			ST_C4: begin
				mul_a = mul_q ^ (mul_q >> 13);
				mul_b = MIX_C4;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod     = mul_a * mul_b;
	assign hash_fin = mul_q ^ (mul_q >> 16);

	// modulo unit
	assign mod_start = (state_q == ST_HF);

	hhs_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_fin),
		.divisor   (nb),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// entry addresses
	assign ins_addr = ADDR_W'((32'(stream_q) * ROWS + 32'(row_q)) * BUCKETS + 32'(mod_rem));
	assign one_addr = ADDR_W'((32'(stream_q) * ROWS + 32'(rowf_q)) * BUCKETS + 32'(bucketf_q));
	assign raddr    = (state_q == ST_MOD) ? ins_addr : one_addr;
	assign waddr    = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign wdata    = (state_q == ST_CLEAR) ? 64'd0 : {upd_key, upd_cnt};

	hhs_ram #(
		.WIDTH (64),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// bucket update
	assign rd_key = rdata[63:32];
	assign rd_cnt = rdata[31:0];
	assign msum   = {1'b0, rd_cnt} + {1'b0, rc_q};

	always_comb begin
		c1      = '0;
		upd_key = rd_key;
		upd_cnt = rd_cnt;
		unique case (op_q)
			OP_INSERT: begin
				if (rd_cnt != 32'd0) begin
					if (rd_key == value_q) begin
						c1 = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
					end else begin
						c1 = rd_cnt - 32'd1;
					end
				end
				if (c1 == 32'd0) begin
					upd_key = value_q;
					upd_cnt = 32'd1;
				end else begin
					upd_cnt = c1;
				end
			end
			OP_MERGE: begin
				if (rd_key == value_q) begin
					upd_cnt = msum[32] ? CNT_MAX : msum[31:0];
				end else if (rd_cnt > rc_q) begin
					upd_cnt = rd_cnt - rc_q;
				end else begin
					upd_key = value_q;
					upd_cnt = rc_q - rd_cnt;
				end
			end
			default: begin
				upd_key = rd_key;
				upd_cnt = rd_cnt;
			end
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and store write
	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (bad_req || skip_req) begin
						state_d = ST_DONE;
					end else if (op == OP_INSERT) begin
						state_d = ST_K1;
					end else begin
						state_d = ST_ONE_RD;
					end
				end
			end
			ST_K1:     state_d = ST_K2;
			ST_K2:     state_d = ST_H5;
			ST_H5:     state_d = ST_C3;
			ST_C3:     state_d = ST_C4;
			ST_C4:     state_d = ST_HF;
			ST_HF:     state_d = ST_MOD;
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_WR;
				end
			end
			ST_ONE_RD: state_d = ST_WR;
			ST_WR: begin
				ram_we = (op_q != OP_READ);
				if (op_q == OP_INSERT && !last_row) begin
					state_d = ST_H5;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(op);
			stream_q   <= stream;
			value_q    <= value;
			rowf_q     <= row;
			bucketf_q  <= bucket;
			rc_q       <= remote_count;
			row_q      <= '0;
			res_key_q  <= '0;
			res_cnt_q  <= '0;
			res_skip_q <= !bad_req && skip_req;
		end
		if (state_q == ST_K1 || state_q == ST_H5 || state_q == ST_C3 || state_q == ST_C4) begin
			mul_q <= prod;
		end
		if (state_q == ST_K2) begin
			k_q <= prod;
		end
		if ((state_q == ST_MOD && mod_done) || state_q == ST_ONE_RD) begin
			addr_q <= raddr;
		end
		if (state_q == ST_WR) begin
			if (op_q == OP_INSERT) begin
				row_q <= row_q + 1'b1;
			end else begin
				res_key_q <= upd_key;
				res_cnt_q <= upd_cnt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			entry_key_q   <= res_key_q;
			entry_count_q <= res_cnt_q;
			skipped_q     <= res_skip_q;
		end
	end

	assign result_valid = result_valid_q;
	assign entry_key    = entry_key_q;
	assign entry_count  = entry_count_q;
	assign skipped      = skipped_q;

	// checks
	`HHS_ASSERT_IMPL(a_no_write_idle, clk, arst_n, ram_we, state_q != ST_IDLE && state_q != ST_DONE, "store written outside a request")
	`HHS_ASSERT_IMPL(a_mod_done_wait, clk, arst_n, mod_done, state_q == ST_MOD, "remainder ready outside modulo wait")
	`HHS_ASSERT_NEXT(a_done_delivers, clk, arst_n, state_q == ST_DONE && out_free, result_valid_q && state_q == ST_IDLE, "finished request not delivered")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heavy_hitter_sketch_unit: requests are queued by a
// stimulus block, sent by a clocked driver with random idle bursts, and each
// result is compared with a local model of the majority-vote sketch.
// ----------------------------------------------------------------------------
module tb import hhs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = HHS_STREAMS * HHS_ROWS * HHS_BUCKETS;

	typedef struct packed {
		op_t         op;
		logic [1:0]  stream;
		logic [31:0] value;
		logic [1:0]  row;
		logic [7:0]  bucket;
		logic [31:0] remote_count;
	} request_t;

	typedef struct packed {
		logic [31:0] entry_key;
		logic [31:0] entry_count;
		logic        skipped;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] op = '0, stream = '0, row = '0;
	logic [31:0] value = '0, remote_count = '0;
	logic [7:0] bucket = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [31:0] entry_key, entry_count;
	logic skipped;

	heavy_hitter_sketch_unit u_dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sketch model state
	logic [31:0] model_seed [SEED_REGS];
	logic [8:0]  model_buckets;
	logic [31:0] model_key [CELLS];
	logic [31:0] model_count [CELLS];

	request_t pending_requests [$];
	entry_t   expected_entries [$];
	int  fail_count = 0;
	bit  quiet_tail = 1'b0;
	bit  send_hold = 1'b0;
	int  send_gap = 0;
	int  stall_gap = 0;

	function automatic logic [31:0] rotl(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] murmur_mix(logic [31:0] seed, logic [31:0] v);
		logic [31:0] k, h;
		k = v * MIX_C1;
		k = rotl(k, 15);
		k = k * MIX_C2;
		h = seed ^ k;
		h = rotl(h, 13);
		h = h * 32'd5 + MIX_ADD;
		h = h ^ (h >> 16);
		h = h * MIX_C3;
		h = h ^ (h >> 13);
		h = h * MIX_C4;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[32] ? 32'hffffffff : s[31:0];
	endfunction

	// apply one request to the model and return its entry
	function automatic entry_t sketch_update(request_t rq);
		entry_t e;
		int nb, c;
		logic [31:0] h;
		e = '0;
		if (rq.op == OP_INSERT) begin
			if (rq.value == 0) begin
				e.skipped = 1'b1;
				return e;
			end
			nb = model_buckets == 0 ? 1 :
				(model_buckets > HHS_BUCKETS ? HHS_BUCKETS : model_buckets);
			for (int r = 0; r < HHS_ROWS; r++) begin
				h = murmur_mix(model_seed[r], rq.value);
				c = (rq.stream * HHS_ROWS + r) * HHS_BUCKETS + int'(h % nb);
				if (model_count[c] != 0) begin
					if (model_key[c] == rq.value) model_count[c] = add_sat(model_count[c], 1);
					else model_count[c] = model_count[c] - 1;
				end
				if (model_count[c] == 0) begin
					model_key[c] = rq.value;
					model_count[c] = 1;
				end
			end
			return e;
		end
		if (rq.op == OP_NONE) return e;
		c = (rq.stream * HHS_ROWS + rq.row) * HHS_BUCKETS + rq.bucket;
		if (rq.op == OP_MERGE) begin
			if (model_key[c] == rq.value) begin
				model_count[c] = add_sat(model_count[c], rq.remote_count);
			end else if (model_count[c] > rq.remote_count) begin
				model_count[c] = model_count[c] - rq.remote_count;
			end else begin
				model_key[c] = rq.value;
				model_count[c] = rq.remote_count - model_count[c];
			end
		end
		e.entry_key = model_key[c];
		e.entry_count = model_count[c];
		return e;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			expected_entries.push_back(sketch_update(request_t'({op, stream, value, row,
				bucket, remote_count})));
		end
		if (!item_valid || !item_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_requests.size() != 0 && !send_hold && arst_n) begin
				request_t rq;
				rq = pending_requests.pop_front();
				item_valid <= 1'b1;
				op <= rq.op;
				stream <= rq.stream;
				value <= rq.value;
				row <= rq.row;
				bucket <= rq.bucket;
				remote_count <= rq.remote_count;
				if (!quiet_tail && $urandom_range(0, 15) == 0)
					send_gap <= $urandom_range(1, 19);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (expected_entries.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				entry_t e;
				e = expected_entries.pop_front();
				if (entry_key !== e.entry_key) begin
					$error("entry_key expected %h actual %h", e.entry_key, entry_key);
					fail_count++;
				end
				if (entry_count !== e.entry_count) begin
					$error("entry_count expected %h actual %h", e.entry_count, entry_count);
					fail_count++;
				end
				if (skipped !== e.skipped) begin
					$error("skipped expected %b actual %b", e.skipped, skipped);
					fail_count++;
				end
			end
		end
		if (stall_gap > 0) begin
			stall_gap <= stall_gap - 1;
			result_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
			stall_gap <= $urandom_range(0, 18);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < SEED_REGS) model_seed[idx] = data;
		else if (idx == REG_BKT) model_buckets = data[8:0];
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || item_valid || expected_entries.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic request_t random_request(logic [31:0] pool []);
		request_t rq;
		int sel;
		rq.stream = $urandom_range(0, 3);
		rq.row = $urandom_range(0, 3);
		rq.bucket = $urandom_range(0, 255);
		rq.value = $urandom_range(0, 9) == 0 ? $urandom() : pool[$urandom_range(0, 7)];
		sel = $urandom_range(0, 3);
		rq.remote_count = sel == 0 ? $urandom() : (sel == 1 ? 32'hffffffff :
			$urandom_range(0, 4));
		sel = $urandom_range(0, 19);
		rq.op = sel < 12 ? OP_INSERT : (sel < 15 ? OP_MERGE : (sel < 19 ? OP_READ : OP_NONE));
		if ($urandom_range(0, 40) == 0) rq.value = 0;
		return rq;
	endfunction

	task automatic random_phase(int n);
		logic [31:0] pool [];
		pool = new[8];
		foreach (pool[i]) pool[i] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 9);
		repeat (n) pending_requests.push_back(random_request(pool));
	endtask

	task automatic push_req(op_t o, logic [1:0] s, logic [31:0] v, logic [1:0] r,
		logic [7:0] b, logic [31:0] rc);
		pending_requests.push_back(request_t'({o, s, v, r, b, rc}));
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < SEED_REGS; i++) model_seed[i] = 2 * i + 1;
		model_buckets = BKT_RESET;
		for (int i = 0; i < CELLS; i++) begin
			model_key[i] = '0;
			model_count[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, saturation, every op
		push_req(OP_INSERT, 0, 32'h0, 0, 0, 0);
		push_req(OP_INSERT, 0, 32'hffffffff, 0, 0, 0);
		push_req(OP_INSERT, 3, 32'h1, 3, 255, 0);
		push_req(OP_INSERT, 3, 32'h1, 0, 0, 0);
		push_req(OP_READ, 3, 0, 3, 255, 0);
		push_req(OP_MERGE, 1, 32'hdeadbeef, 2, 7, 32'hfffffffe);
		push_req(OP_MERGE, 1, 32'hdeadbeef, 2, 7, 32'h5);
		push_req(OP_MERGE, 1, 32'h12345678, 2, 7, 32'h3);
		push_req(OP_MERGE, 1, 32'h12345678, 2, 7, 32'hffffffff);
		push_req(OP_MERGE, 1, 32'h0, 2, 7, 32'h0);
		push_req(OP_MERGE, 2, 32'haaaa5555, 1, 255, 32'h0);
		push_req(OP_READ, 1, 0, 2, 7, 0);
		push_req(OP_NONE, 3, 32'hffffffff, 3, 255, 32'hffffffff);
		push_req(OP_READ, 0, 32'hffffffff, 0, 0, 32'hffffffff);
		wait_drained();

		// seeds at extremes, smallest bucket count and zero
		reg_write(0, 32'hffffffff);
		reg_write(1, 32'h0);
		reg_write(2, 32'h80000001);
		reg_write(3, $urandom() | 1);
		reg_write(REG_BKT, 9'd1);
		random_phase(120);
		wait_drained();
		reg_write(REG_BKT, 9'd0);
		random_phase(60);
		wait_drained();

		// small odd count, sender paused midway until all results are back
		reg_write(REG_BKT, 9'd7);
		for (int i = 0; i < SEED_REGS; i++) reg_write(i, $urandom());
		random_phase(150);
		while (pending_requests.size() > 75) @(posedge clk);
		send_hold = 1'b1;
		while (item_valid || expected_entries.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		send_hold = 1'b0;
		wait_drained();
		random_phase(50);
		wait_drained();

		// bucket count above range
		reg_write(REG_BKT, 9'd511);
		random_phase(150);
		wait_drained();

		// full range, then no idling
		reg_write(REG_BKT, 9'd256);
		random_phase(130);
		wait_drained();
		quiet_tail = 1'b1;
		random_phase(90);
		wait_drained();

		if (fail_count == 0) begin
			$display("PASS heavy_hitter_sketch_unit");
		end else begin
			$display("FAIL heavy_hitter_sketch_unit");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("FAIL heavy_hitter_sketch_unit");
		$finish;
	end
endmodule
